@@ rtl/crs_pkg.sv @@
package crs_pkg;

	localparam logic [7:0] GF_POLY_LOW = 8'h1D;

	localparam logic [7:0] CFG_DATA_SHARDS   = 8'd0;
	localparam logic [7:0] CFG_PARITY_SHARDS = 8'd1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] shard_index;
		logic       final_column;
	} in_t;

	typedef struct packed {
		logic [7:0] out_shard;
		logic [7:0] out_byte;
		logic       column_done;
		logic       block_done;
	} out_t;

	// One accepted data byte on its way from the front to the back.
	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] shard_index;
		logic       final_column;
		logic       last;
	} entry_t;

	// Effective shard counts, already clamped.
	typedef struct packed {
		logic [7:0] k;
		logic [4:0] m;
	} cfg_t;

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] r;
		x = a;
		r = 8'h00;
		for (int n = 0; n < 8; n++) begin
			if (b[n]) begin
				r = r ^ x;
			end
			x = x[7] ? ({x[6:0], 1'b0} ^ GF_POLY_LOW) : {x[6:0], 1'b0};
		end
		return r;
	endfunction

	// Inverse table from the powers of the generator 2; zero maps to zero.
	function automatic logic [255:0][7:0] build_inv_table();
		logic [255:0][7:0] expt;
		logic [255:0][7:0] inv;
		logic [7:0]        x;
		expt = '0;
		inv = '0;
		x = 8'h01;
		for (int n = 0; n < 255; n++) begin
			expt[n] = x;
			x = gf_mul(x, 8'h02);
		end
		for (int n = 0; n < 255; n++) begin
			inv[expt[n]] = (n == 0) ? expt[0] : expt[255 - n];
		end
		return inv;
	endfunction

	localparam logic [255:0][7:0] GF_INV_TBL = build_inv_table();

endpackage

@@ rtl/crs_fifo.sv @@
module crs_fifo #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  crs_pkg::entry_t  wr_entry,
	output logic             full,
	input  logic             rd,
	output crs_pkg::entry_t  rd_entry,
	output logic             valid
);
	import crs_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	entry_t           slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign valid    = (count_q != '0);
	assign rd_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (wr && !rd) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (rd && !wr) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

@@ rtl/crs_front.sv @@
module crs_front #(
	parameter int MAX_PARITY = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  crs_pkg::in_t     item,
	input  logic             cfg_write,
	input  logic [7:0]       cfg_index,
	input  logic [7:0]       cfg_data,
	output crs_pkg::cfg_t    cfg,
	output logic             q_push,
	output crs_pkg::entry_t  q_entry,
	input  logic             q_full
);
	import crs_pkg::*;

	logic [7:0] data_shards_q;
	logic [4:0] parity_shards_q;
	logic [7:0] k_eff;
	logic [8:0] m_wide;
	logic [8:0] m_limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_shards_q   <= 8'd1;
			parity_shards_q <= 5'd0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_DATA_SHARDS:   data_shards_q   <= cfg_data;
				CFG_PARITY_SHARDS: parity_shards_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// A data shard count of zero behaves as one; parity count is held to what fits.
	always_comb begin
		k_eff   = (data_shards_q == 8'd0) ? 8'd1 : data_shards_q;
		m_limit = 9'd256 - {1'b0, k_eff};
		m_wide  = {4'b0000, parity_shards_q};
		if (m_wide > 9'(MAX_PARITY)) begin
			m_wide = 9'(MAX_PARITY);
		end
		if (m_wide > m_limit) begin
			m_wide = m_limit;
		end
	end

	assign cfg.k = k_eff;
	assign cfg.m = m_wide[4:0];

	// Bytes of shards beyond the configured count are accepted and dropped.
	assign full                 = q_full;
	assign q_push               = push && !q_full && (item.shard_index < k_eff);
	assign q_entry.data_byte    = item.data_byte;
	assign q_entry.shard_index  = item.shard_index;
	assign q_entry.final_column = item.final_column;
	assign q_entry.last         = (item.shard_index == 8'(k_eff - 8'd1));

endmodule

@@ rtl/crs_back.sv @@
module crs_back #(
	parameter int MAX_PARITY = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  crs_pkg::cfg_t    cfg,
	input  logic             q_valid,
	input  crs_pkg::entry_t  q_entry,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output crs_pkg::out_t    result
);
	import crs_pkg::*;

	logic [7:0] acc_q     [MAX_PARITY];
	logic [7:0] par_q     [MAX_PARITY];
	logic [7:0] mac       [MAX_PARITY];
	logic [7:0] par_shift [MAX_PARITY];
	logic [4:0] par_left_q;
	logic [7:0] par_shard_q;
	logic       par_fin_q;
	logic       out_valid_q;
	out_t       out_q;
	logic       advance;
	logic       emitting;
	logic       take;

	for (genvar i = 0; i < MAX_PARITY; i++) begin : g_lane
		localparam logic [5:0] LANE = 6'(i);
		logic [7:0] coeff_idx;
		logic [7:0] prod;
		logic       en;
		assign en        = ({1'b0, cfg.m} > LANE);
		assign coeff_idx = 8'(cfg.k + 8'(i)) ^ q_entry.shard_index;
		assign prod      = en ? gf_mul(GF_INV_TBL[coeff_idx], q_entry.data_byte) : 8'h00;
		assign mac[i]    = acc_q[i] ^ prod;
		if (i < MAX_PARITY - 1) begin : g_mid
			assign par_shift[i] = par_q[i+1];
		end else begin : g_end
			assign par_shift[i] = 8'h00;
		end
	end

	assign emitting = (par_left_q != 5'd0);
	assign advance  = !out_valid_q || pop;
	assign take     = advance && !emitting && q_valid;
	assign q_pop    = take;
	assign empty    = !out_valid_q;
	assign result   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			par_left_q  <= 5'd0;
			for (int i = 0; i < MAX_PARITY; i++) begin
				acc_q[i] <= 8'h00;
			end
		end else if (advance) begin
			out_valid_q <= emitting || q_valid;
			if (emitting) begin
				par_left_q <= 5'(par_left_q - 5'd1);
			end else if (take) begin
				if (q_entry.last) begin
					par_left_q <= cfg.m;
				end
				for (int i = 0; i < MAX_PARITY; i++) begin
					acc_q[i] <= q_entry.last ? 8'h00 : mac[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (emitting) begin
				out_q.out_shard   <= par_shard_q;
				out_q.out_byte    <= par_q[0];
				out_q.column_done <= (par_left_q == 5'd1);
				out_q.block_done  <= (par_left_q == 5'd1) && par_fin_q;
				par_shard_q       <= 8'(par_shard_q + 8'd1);
				for (int i = 0; i < MAX_PARITY; i++) begin
					par_q[i] <= par_shift[i];
				end
			end else if (take) begin
				out_q.out_shard   <= q_entry.shard_index;
				out_q.out_byte    <= q_entry.data_byte;
				out_q.column_done <= !(q_entry.last && (cfg.m != 5'd0));
				out_q.block_done  <= q_entry.last && (cfg.m == 5'd0) && q_entry.final_column;
				if (q_entry.last) begin
					par_shard_q <= cfg.k;
					par_fin_q   <= q_entry.final_column;
					for (int i = 0; i < MAX_PARITY; i++) begin
						par_q[i] <= mac[i];
					end
				end
			end
		end
	end

endmodule

@@ rtl/cauchy_rs_parity_encoder_top.sv @@
// Systematic Cauchy Reed-Solomon parity encoder over GF(2^8), polynomial 0x11D.
// Input words (push/full) carry one data byte of shard shard_index of the
// current column. Each byte with a shard index below the data shard count is
// passed straight through as a result word; bytes of higher shards are taken
// and dropped. After the byte of the last data shard, the parity bytes of the
// column follow as further result words, and the accumulators start afresh.
// Result words leave through empty/pop, oldest first, from an output register.
// A data byte passes through the queue and the output register on its way out.
// Throughput: one word per cycle on both sides while pop stays high; the output
// register is the limit, so a column of K bytes and M parity shards makes K+M
// words, and once the queue has filled the input waits while parity words drain.
// Between the front and the back sits a short queue; when the receiver holds
// pop low the result word stays put, the queue fills, and full rises.
// Reset clears the queue, the output register and all parity accumulators,
// and sets one data shard and no parity shards. The configuration port writes
// a register whenever cfg_write is high; use it only when idle (not enforced).
module cauchy_rs_parity_encoder_top #(
	parameter int MAX_PARITY  = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  crs_pkg::in_t  item,
	output logic          empty,
	input  logic          pop,
	output crs_pkg::out_t result,
	input  logic          cfg_write,
	input  logic [7:0]    cfg_index,
	input  logic [7:0]    cfg_data
);
	import crs_pkg::*;

	cfg_t   cfg;
	entry_t q_wr_entry;
	entry_t q_rd_entry;
	logic   q_push;
	logic   q_full;
	logic   q_pop;
	logic   q_valid;

	// The front holds the shard counts and decides which bytes go on.
	crs_front #(
		.MAX_PARITY(MAX_PARITY)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg),
		.q_push(q_push),
		.q_entry(q_wr_entry),
		.q_full(q_full)
	);

	crs_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(q_push),
		.wr_entry(q_wr_entry),
		.full(q_full),
		.rd(q_pop),
		.rd_entry(q_rd_entry),
		.valid(q_valid)
	);

	// The back accumulates parity in all lanes at once and sequences the words out.
	crs_back #(
		.MAX_PARITY(MAX_PARITY)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.q_valid(q_valid),
		.q_entry(q_rd_entry),
		.q_pop(q_pop),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

`ifndef SYNTHESIS
	// The back never reads from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("queue read while empty");

	// Nothing is written into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("queue written while full");

	// Bytes of shards beyond the data shard count never reach the back.
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && (item.shard_index >= cfg.k)) |-> !q_push)
		else $error("out of range shard entered the queue");

	// A word that ends a block also ends its column.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.block_done) |-> result.column_done)
		else $error("block end without column end");
`endif

endmodule

@@ sim/tb.sv @@
module tb;

	import crs_pkg::*;

	// Parity accumulators in the block are this deep; the emitted count is clamped to it.
	localparam int unsigned MAX_PARITY   = 16;
	// Field polynomial x^8+x^4+x^3+x^2+1.
	localparam logic [8:0]  FIELD_POLY   = 9'h11D;
	// Data words (shard below K) wanted from the random part.
	localparam int unsigned RANDOM_WORDS = 310;
	// Cycles allowed after the last expected word before the block counts as idle.
	localparam int unsigned SETTLE_CYCLES = 8;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	in_t        item = '0;
	logic       empty;
	logic       pop = 1'b0;
	out_t       result;
	logic       cfg_write = 1'b0;
	logic [7:0] cfg_index = 8'h00;
	logic [7:0] cfg_data = 8'h00;

	// Words waiting to be offered to the block, and result words predicted but not yet seen.
	in_t  pending[$];
	out_t words_due[$];

	// Our own copy of the block's state: the shard counts as written and the accumulators.
	logic [7:0] k_shadow = 8'd1;
	logic [4:0] m_shadow = 5'd0;
	logic [7:0] parity_acc[MAX_PARITY];
	logic [7:0] gf_recip[256];

	int unsigned mismatch_count = 0;
	int unsigned data_words_queued = 0;
	int unsigned k_active = 1;
	bit          calm_send = 1'b0;
	bit          calm_take = 1'b0;
	int unsigned send_gap = 0;
	int unsigned take_gap = 0;

	cauchy_rs_parity_encoder_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Multiplication in GF(2^8): the multiplier is consumed from its low end while the
	// multiplicand is doubled and reduced by the field polynomial.
	function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] sh;
		logic [7:0] mul;
		acc = 8'h00;
		sh = a;
		mul = b;
		while (mul != 8'h00) begin
			if (mul[0]) begin
				acc = acc ^ sh;
			end
			sh = {sh[6:0], 1'b0} ^ (sh[7] ? FIELD_POLY[7:0] : 8'h00);
			mul = mul >> 1;
		end
		return acc;
	endfunction

	// Gaps between words: usually none, often a short one, now and then a long pause.
	// A calm phase has no gaps at all.
	function automatic int unsigned pick_gap(input bit calm);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55) begin
			return 0;
		end else if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Works out the result words of one accepted input word and updates the accumulators.
	// A word for a shard at or above K is dropped without touching anything. Otherwise the
	// byte is passed through, every active accumulator takes in its share, and the byte of
	// the last data shard closes the column with the parity words.
	task automatic encode_word(input in_t w);
		int unsigned k;
		int unsigned m;
		int unsigned j;
		logic [7:0]  idx;
		logic        last;
		out_t        r;
		k = (k_shadow == 8'd0) ? 1 : 32'(k_shadow);
		m = 32'(m_shadow);
		if (m > MAX_PARITY) begin
			m = MAX_PARITY;
		end
		if (m > 256 - k) begin
			m = 256 - k;
		end
		j = 32'(w.shard_index);
		if (j < k) begin
			for (int i = 0; i < m; i++) begin
				idx = 8'(k + i);
				idx = idx ^ w.shard_index;
				parity_acc[i] = parity_acc[i] ^ gf_times(gf_recip[idx], w.data_byte);
			end
			last = (j == k - 1);
			r.out_shard = w.shard_index;
			r.out_byte = w.data_byte;
			r.column_done = !(last && m != 0);
			r.block_done = last && m == 0 && w.final_column;
			words_due.push_back(r);
			if (last) begin
				for (int i = 0; i < m; i++) begin
					r.out_shard = 8'(k + i);
					r.out_byte = parity_acc[i];
					r.column_done = (i == m - 1);
					r.block_done = (i == m - 1) && w.final_column;
					words_due.push_back(r);
				end
				for (int i = 0; i < MAX_PARITY; i++) begin
					parity_acc[i] = 8'h00;
				end
			end
		end
	endtask

	// Sender side. A word offered with push stays put until it is taken; after that the
	// next one follows at once or after a random gap.
	always @(posedge clk) begin
		if (push && !full) begin
			encode_word(item);
		end
		if (push && full) begin
			push <= 1'b1;
		end else if (send_gap != 0) begin
			send_gap = send_gap - 1;
			push <= 1'b0;
		end else if (pending.size() != 0) begin
			item <= pending.pop_front();
			push <= 1'b1;
			send_gap = pick_gap(calm_send);
		end else begin
			push <= 1'b0;
		end
	end

	// Receiver side. Each word taken is checked against the oldest prediction, then pop
	// may drop for a random while to stall the block.
	always @(posedge clk) begin
		if (pop && !empty) begin
			if (words_due.size() == 0) begin
				mismatch_count++;
				$display("%0t: no word expected, got shard %0d byte %h col %b blk %b", $time,
					result.out_shard, result.out_byte, result.column_done, result.block_done);
			end else if (result !== words_due[0]) begin
				mismatch_count++;
				$display("%0t: expected shard %0d byte %h col %b blk %b, got shard %0d byte %h col %b blk %b",
					$time, words_due[0].out_shard, words_due[0].out_byte,
					words_due[0].column_done, words_due[0].block_done,
					result.out_shard, result.out_byte, result.column_done, result.block_done);
				void'(words_due.pop_front());
			end else begin
				void'(words_due.pop_front());
			end
			take_gap = pick_gap(calm_take);
		end
		if (take_gap != 0) begin
			take_gap = take_gap - 1;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// Queues one input word; words below the current K are the ones that count.
	task automatic queue_word(input int unsigned j, input logic [7:0] b, input bit fin);
		in_t w;
		w.data_byte = b;
		w.shard_index = 8'(j);
		w.final_column = fin;
		pending.push_back(w);
		if (j < k_active) begin
			data_words_queued++;
		end
	endtask

	// Waits until everything offered has been taken and every predicted word has come out,
	// then waits out a settling time so that nothing is left in flight inside the block.
	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (pending.size() != 0 || push || words_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes both shard counts once the block is idle. The accumulators are left alone, as
	// they are in the block.
	task automatic set_shards(input logic [7:0] k, input logic [4:0] m);
		wait_idle();
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_DATA_SHARDS;
		cfg_data <= k;
		k_shadow = k;
		@(posedge clk);
		cfg_index <= CFG_PARITY_SHARDS;
		cfg_data <= {3'b000, m};
		m_shadow = m;
		@(posedge clk);
		cfg_write <= 1'b0;
		k_active = (k == 8'd0) ? 1 : 32'(k);
	endtask

	initial begin
		int unsigned k;
		int unsigned cols;
		int unsigned start;
		int unsigned roll;
		bit          fin;
		// The reciprocal table is found by search, so it owes nothing to the generator.
		gf_recip[0] = 8'h00;
		for (int a = 1; a < 256; a++) begin
			for (int b = 1; b < 256; b++) begin
				if (gf_times(8'(a), 8'(b)) == 8'h01) begin
					gf_recip[a] = 8'(b);
				end
			end
		end
		for (int i = 0; i < MAX_PARITY; i++) begin
			parity_acc[i] = 8'h00;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. First the counts left by reset: one data shard, no parity, so every
		// byte of shard 0 closes its column; higher shards are dropped.
		@(negedge clk);
		queue_word(0, 8'h00, 1'b0);
		queue_word(0, 8'hFF, 1'b1);
		queue_word(1, 8'h55, 1'b1);
		queue_word(254, 8'hAA, 1'b1);
		queue_word(255, 8'h0F, 1'b0);

		// A data shard count of zero behaves as one; sixteen parity words follow each byte.
		set_shards(8'd0, 5'd16);
		queue_word(0, 8'h80, 1'b1);
		queue_word(0, 8'h01, 1'b0);

		// A plain column with the final flag set too early, then shards out of order and
		// repeated, and a dropped shard with index K.
		set_shards(8'd4, 5'd3);
		queue_word(0, 8'hFF, 1'b0);
		queue_word(1, 8'h00, 1'b1);
		queue_word(2, 8'h7F, 1'b0);
		queue_word(3, 8'h80, 1'b0);
		queue_word(2, 8'h11, 1'b0);
		queue_word(0, 8'h22, 1'b0);
		queue_word(0, 8'h33, 1'b1);
		queue_word(3, 8'h44, 1'b1);
		queue_word(4, 8'h99, 1'b1);

		// The parity count changes in the middle of a column: the accumulators carry on and
		// the close of the column uses the new count.
		queue_word(0, 8'hC3, 1'b0);
		queue_word(1, 8'h3C, 1'b0);
		set_shards(8'd4, 5'd5);
		queue_word(3, 8'h5A, 1'b1);

		// The largest K leaves room for one parity shard only, whatever is asked for.
		set_shards(8'd255, 5'd31);
		queue_word(254, 8'hFF, 1'b1);
		queue_word(0, 8'h12, 1'b0);
		queue_word(254, 8'h34, 1'b0);

		// Clamped by K rather than by the accumulator depth.
		set_shards(8'd250, 5'd20);
		queue_word(249, 8'h9E, 1'b1);

		// No parity at all with a wider column.
		set_shards(8'd16, 5'd0);
		queue_word(15, 8'hE7, 1'b1);

		// Random part: mostly whole columns in ascending order with random bytes, with a
		// sprinkling of dropped shards, skipped and repeated shards. Wide columns start close
		// to their end so that they stay short.
		data_words_queued = 0;
		while (data_words_queued < RANDOM_WORDS) begin
			roll = $urandom_range(0, 9);
			if (roll < 6) begin
				k = $urandom_range(1, 8);
			end else if (roll < 9) begin
				k = $urandom_range(9, 40);
			end else if ($urandom_range(0, 3) == 0) begin
				k = 0;
			end else begin
				k = $urandom_range(200, 255);
			end
			set_shards(8'(k), 5'($urandom_range(0, 31)));
			calm_send = ($urandom_range(0, 3) == 0);
			calm_take = ($urandom_range(0, 3) == 0);
			cols = $urandom_range(1, 4);
			for (int c = 0; c < cols; c++) begin
				start = (k_active > 16) ? k_active - $urandom_range(1, 6) : 0;
				for (int j = start; j < k_active; j++) begin
					if (j == k_active - 1) begin
						fin = (c == cols - 1);
					end else begin
						fin = 1'($urandom_range(0, 1));
					end
					roll = $urandom_range(0, 19);
					if (roll == 0) begin
						queue_word($urandom_range(k_active, 255), 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)));
					end
					if (roll == 1 && j != k_active - 1) begin
						continue;
					end
					queue_word(j, 8'($urandom_range(0, 255)), fin);
					if (roll == 2) begin
						queue_word(j, 8'($urandom_range(0, 255)), fin);
					end
				end
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && words_due.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Guard against a hang: far longer than the slowest correct run could take.
	initial begin
		#10000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
